FILE: src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int FREE_ENTRIES = 32;
    localparam int HEAP_UNITS   = 8192;
    localparam int HEADER_BYTES = 8;
    localparam int MIN_REMAIN   = 16;

    localparam int IDX_W  = $clog2(FREE_ENTRIES);
    localparam int CNT_W  = $clog2(FREE_ENTRIES + 1);
    localparam int UNIT_W = $clog2(HEAP_UNITS);
    localparam int OFF_W  = 17;
    localparam int SZ_W   = 18;
    localparam int HDR_W  = OFF_W + 1;
    localparam logic [OFF_W:0] HEAP_SPAN = (OFF_W + 1)'(HEAP_UNITS * 8);

    localparam int IN_W  = 56;
    localparam int OUT_W = 64;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_COALESCE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_BAD_PTR = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_HEAP_BASE  = 2'd0,
        CFG_HEAP_LIMIT = 2'd1,
        CFG_GROW_SIZE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_CLEAR, OP_LOAD, OP_NEXT, OP_REMOVE, OP_GROW, OP_CARVE,
        OP_INSERT, OP_MARK, OP_FREAD, OP_FCOMMIT, OP_MERGE, OP_RESULT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_SCAN, S_A_GROW, S_CARVE, S_INS_SCAN, S_MARK,
        S_F_PTR, S_F_CHECK, S_C_STEP, S_DONE
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
        logic    is_alloc;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_end;
        logic fit;
        logic ins_here;
        logic full;
        logic grow_ok;
        logic split;
        logic ptr_ok;
        logic hdr_signed;
        logic merge_end;
    } dp_stat_t;

endpackage

FILE: src/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Command sequencer: walks the free table and drives datapath operations.
// ----------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic [1:0] in_command,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    alloc_reg, alloc_next;
    logic    out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            st_reg        <= ST_OK;
            alloc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        alloc_next = alloc_reg;
        unique case (state_reg)
            S_CLEAR:
                if (stat.clear_last) state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                begin
                    st_next    = ST_OK;
                    alloc_next = (in_command == CMD_ALLOC);
                    priority case (in_command)
                        CMD_ALLOC:    state_next = S_A_SCAN;
                        CMD_FREE:     state_next = S_F_PTR;
                        CMD_COALESCE: state_next = S_C_STEP;
                        default:      state_next = S_DONE;
                    endcase
                end
            S_A_SCAN:
                if (stat.scan_end)  state_next = S_A_GROW;
                else if (stat.fit)  state_next = S_CARVE;
            S_A_GROW:
                if (stat.grow_ok) state_next = S_CARVE;
                else
                begin
                    st_next    = ST_OOM;
                    state_next = S_DONE;
                end
            S_CARVE:
                state_next = stat.split ? S_INS_SCAN : S_MARK;
            S_INS_SCAN:
                if (stat.scan_end || stat.ins_here)
                    state_next = alloc_reg ? S_MARK : S_DONE;
            S_MARK:
                state_next = S_DONE;
            S_F_PTR:
                if (stat.ptr_ok) state_next = S_F_CHECK;
                else
                begin
                    st_next    = ST_BAD_PTR;
                    state_next = S_DONE;
                end
            S_F_CHECK:
                if (!stat.hdr_signed)
                begin
                    st_next    = ST_BAD_PTR;
                    state_next = S_DONE;
                end
                else if (stat.full)
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
                else state_next = S_INS_SCAN;
            S_C_STEP:
                if (stat.merge_end) state_next = S_DONE;
            S_DONE:
                if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op       = OP_NOP;
        cmd.status   = st_reg;
        cmd.is_alloc = alloc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:  cmd.op = OP_CLEAR;
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op       = OP_LOAD;
                    cmd.is_alloc = (in_command == CMD_ALLOC);
                end
            S_A_SCAN:
                if (!stat.scan_end) cmd.op = stat.fit ? OP_REMOVE : OP_NEXT;
            S_A_GROW:
                if (stat.grow_ok) cmd.op = OP_GROW;
            S_CARVE:  cmd.op = OP_CARVE;
            S_INS_SCAN:
                cmd.op = (stat.scan_end || stat.ins_here) ? OP_INSERT : OP_NEXT;
            S_MARK:   cmd.op = OP_MARK;
            S_F_PTR:
                if (stat.ptr_ok) cmd.op = OP_FREAD;
            S_F_CHECK:
                if (stat.hdr_signed && !stat.full) cmd.op = OP_FCOMMIT;
            S_C_STEP:
                if (!stat.merge_end) cmd.op = OP_MERGE;
            S_DONE:
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                end
            default:  cmd.op = OP_NOP;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: src/ffa_dp.sv
// ----------------------------------------------------------------------------
// ffa_dp
// Datapath: free table, header store, break pointer and result registers.
// ----------------------------------------------------------------------------
module ffa_dp
    import ffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [16:0]       in_req_bytes,
    input  logic [31:0]       in_pointer,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output dp_stat_t          stat,
    output logic [OUT_W-1:0]  result
);

    logic [31:0]      base_reg;
    logic [16:0]      limit_reg, grow_reg;
    logic [OFF_W-1:0] break_reg;
    logic [CNT_W-1:0] count_reg, idx_reg;
    logic             started_reg;
    logic [UNIT_W-1:0] clr_reg;

    logic [OFF_W-1:0] ent_start [FREE_ENTRIES];
    logic [OFF_W-1:0] ent_bytes [FREE_ENTRIES];
    logic [HDR_W-1:0] hdr_mem   [HEAP_UNITS];
    logic [HDR_W-1:0] hdr_rd_reg;

    logic [SZ_W-1:0]  size_reg, need_reg;
    logic [OFF_W-1:0] off_reg, chunk_reg, cs_reg, actual_reg;
    logic [OFF_W-1:0] ins_start_reg, ins_bytes_reg, cur_start_reg, cur_bytes_reg;
    logic             ptr_ok_reg;
    logic [OUT_W-1:0] result_reg;

    logic [IDX_W-1:0] rd_i, nx_i;
    logic [CNT_W-1:0] nx_idx;
    logic [SZ_W-1:0]  size_rnd, g8, grow_amt, rem;
    logic [OFF_W:0]   lim;
    logic [OFF_W+1:0] brk_sum;
    logic [OFF_W-1:0] at, merge_sum;
    logic             merge_hit;
    logic [31:0]      hdr_addr, off_full;
    logic             mem_we;
    logic [UNIT_W-1:0] mem_wa;
    logic [HDR_W-1:0] mem_wd;

    assign rd_i   = idx_reg[IDX_W-1:0];
    assign nx_idx = idx_reg + 1'b1;
    assign nx_i   = nx_idx[IDX_W-1:0];

    always_comb
    begin
        size_rnd = ({1'b0, in_req_bytes} + SZ_W'(7)) & ~SZ_W'(7);
        if (size_rnd < SZ_W'(8)) size_rnd = SZ_W'(8);
    end

    assign g8       = {1'b0, grow_reg & ~17'd7};
    assign grow_amt = (need_reg <= g8) ? g8 : need_reg;
    assign lim      = ({1'b0, limit_reg} > HEAP_SPAN) ? HEAP_SPAN : {1'b0, limit_reg};
    assign brk_sum  = {2'b00, break_reg} + {1'b0, grow_amt};
    assign rem      = {1'b0, cs_reg} - size_reg - SZ_W'(HEADER_BYTES);
    assign at       = chunk_reg + OFF_W'(HEADER_BYTES) + size_reg[OFF_W-1:0];
    assign merge_sum = cur_bytes_reg + ent_bytes[nx_i];
    assign merge_hit = ({1'b0, cur_start_reg} + {1'b0, cur_bytes_reg})
                       == {1'b0, ent_start[nx_i]};
    assign hdr_addr = in_pointer - 32'(HEADER_BYTES);
    assign off_full = hdr_addr - base_reg;

    always_comb
    begin
        stat.clear_last = (clr_reg == UNIT_W'(HEAP_UNITS - 1));
        stat.scan_end   = (idx_reg >= count_reg);
        stat.fit        = ({1'b0, ent_bytes[rd_i]} >= need_reg);
        stat.ins_here   = (ent_start[rd_i] > ins_start_reg);
        stat.full       = (count_reg == CNT_W'(FREE_ENTRIES));
        stat.grow_ok    = (brk_sum <= {1'b0, lim});
        stat.split      = (rem >= SZ_W'(MIN_REMAIN)) && (count_reg != CNT_W'(FREE_ENTRIES));
        stat.ptr_ok     = ptr_ok_reg;
        stat.hdr_signed = hdr_rd_reg[HDR_W-1];
        stat.merge_end  = ({1'b0, nx_idx} >= {1'b0, count_reg});
    end

    // header store write port
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        unique case (cmd.op)
            OP_CLEAR:   mem_we = 1'b1;
            OP_CARVE:
            begin
                mem_we = stat.split;
                mem_wa = at[UNIT_W+2:3];
            end
            OP_MARK:
            begin
                mem_we = 1'b1;
                mem_wa = chunk_reg[UNIT_W+2:3];
                mem_wd = {1'b1, actual_reg};
            end
            OP_FCOMMIT:
            begin
                mem_we = 1'b1;
                mem_wa = off_reg[UNIT_W+2:3];
            end
            default:    mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) hdr_mem[mem_wa] <= mem_wd;
        if (cmd.op == OP_FREAD) hdr_rd_reg <= hdr_mem[off_reg[UNIT_W+2:3]];
    end

    // free table rows
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FREE_ENTRIES; k++)
        begin
            unique case (cmd.op)
                OP_REMOVE:
                    if (CNT_W'(k) >= idx_reg && k < FREE_ENTRIES - 1)
                    begin
                        ent_start[k] <= ent_start[(k + 1) % FREE_ENTRIES];
                        ent_bytes[k] <= ent_bytes[(k + 1) % FREE_ENTRIES];
                    end
                OP_INSERT:
                    if (CNT_W'(k) == idx_reg)
                    begin
                        ent_start[k] <= ins_start_reg;
                        ent_bytes[k] <= ins_bytes_reg;
                    end
                    else if (CNT_W'(k) > idx_reg && k > 0)
                    begin
                        ent_start[k] <= ent_start[(k + FREE_ENTRIES - 1) % FREE_ENTRIES];
                        ent_bytes[k] <= ent_bytes[(k + FREE_ENTRIES - 1) % FREE_ENTRIES];
                    end
                OP_MERGE:
                    if (merge_hit)
                    begin
                        if (CNT_W'(k) == idx_reg) ent_bytes[k] <= merge_sum;
                        else if (CNT_W'(k) > idx_reg && k < FREE_ENTRIES - 1)
                        begin
                            ent_start[k] <= ent_start[(k + 1) % FREE_ENTRIES];
                            ent_bytes[k] <= ent_bytes[(k + 1) % FREE_ENTRIES];
                        end
                    end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                size_reg      <= size_rnd;
                need_reg      <= size_rnd + SZ_W'(HEADER_BYTES);
                off_reg       <= off_full[OFF_W-1:0];
                ptr_ok_reg    <= started_reg && (in_pointer >= 32'(HEADER_BYTES))
                                 && (hdr_addr >= base_reg)
                                 && (off_full < {15'd0, break_reg})
                                 && (off_full[2:0] == 3'd0);
                cur_start_reg <= ent_start[0];
                cur_bytes_reg <= ent_bytes[0];
            end
            OP_REMOVE:
            begin
                chunk_reg <= ent_start[rd_i];
                cs_reg    <= ent_bytes[rd_i];
            end
            OP_GROW:
            begin
                chunk_reg <= break_reg;
                cs_reg    <= grow_amt[OFF_W-1:0];
            end
            OP_CARVE:
            begin
                ins_start_reg <= at;
                ins_bytes_reg <= rem[OFF_W-1:0];
                actual_reg    <= stat.split ? (size_reg[OFF_W-1:0] + OFF_W'(HEADER_BYTES))
                                            : cs_reg;
            end
            OP_FCOMMIT:
            begin
                ins_start_reg <= off_reg;
                ins_bytes_reg <= hdr_rd_reg[OFF_W-1:0];
            end
            OP_MERGE:
                if (merge_hit) cur_bytes_reg <= merge_sum;
                else
                begin
                    cur_start_reg <= ent_start[nx_i];
                    cur_bytes_reg <= ent_bytes[nx_i];
                end
            OP_RESULT:
                if (cmd.is_alloc && cmd.status == ST_OK)
                    result_reg <= {7'd0, count_reg, actual_reg,
                                   base_reg + {15'd0, chunk_reg} + 32'(HEADER_BYTES),
                                   cmd.status};
                else
                    result_reg <= {7'd0, count_reg, 17'd0, 32'd0, cmd.status};
            default: ;
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            limit_reg   <= 17'd65536;
            grow_reg    <= 17'd8192;
            break_reg   <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            started_reg <= 1'b0;
            clr_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                priority case (cfg_index)
                    CFG_HEAP_BASE:  base_reg  <= cfg_data;
                    CFG_HEAP_LIMIT: limit_reg <= cfg_data[16:0];
                    CFG_GROW_SIZE:  grow_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_CLEAR:   clr_reg <= clr_reg + 1'b1;
                OP_LOAD:
                begin
                    idx_reg <= '0;
                    if (cmd.is_alloc) started_reg <= 1'b1;
                end
                OP_NEXT:    idx_reg <= nx_idx;
                OP_REMOVE:  count_reg <= count_reg - 1'b1;
                OP_GROW:    break_reg <= brk_sum[OFF_W-1:0];
                OP_CARVE:   idx_reg <= '0;
                OP_FCOMMIT: idx_reg <= '0;
                OP_INSERT:  count_reg <= count_reg + 1'b1;
                OP_MERGE:
                    if (merge_hit) count_reg <= count_reg - 1'b1;
                    else           idx_reg   <= nx_idx;
                default: ;
            endcase
        end
    end

    assign result = result_reg;

endmodule

FILE: src/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// Heap allocator: allocate, free and coalesce over an address-ordered table.
// ----------------------------------------------------------------------------
// Table walk: allocate, free and coalesce step through the free table one entry per
//   cycle, over a free-table fill of up to 32 entries.
// Flow: one command in flight; the input reopens in the cycle the result turns valid,
//   later while an earlier result still waits.
// Reset: asynchronous, active low; a pass then clears all 8192 header-store entries.
module first_fit_free_list_allocator
    import ffa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // command[1:0], req_bytes[18:2], pointer[50:19]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // status[1:0], address[33:2], alloc_bytes[50:34],
                                        // free_count[56:51]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes land at once; software must write only while idle (not enforced).
    assign cfg_ready = 1'b1;

    // Sequence each command through the datapath.
    ffa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tdata[1:0]),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Hold the free table, header store, break and result register.
    ffa_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_req_bytes    (s_tdata[18:2]),
        .in_pointer      (s_tdata[50:19]),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .stat            (stat),
        .result          (m_tdata)
    );

    // A failed command hands out no address.
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[33:2] == 32'd0))
        else $error("failed transaction carries an address");

    // The table never reports more entries than it holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[56:51] <= 6'(FREE_ENTRIES)))
        else $error("free count beyond table depth");

    // One command at a time: after a transaction the input closes.
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened while a command is in flight");

    // A rejected free pointer never returns a chunk size.
    a_free_no_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == ST_BAD_PTR) |-> (m_tdata[50:34] == 17'd0))
        else $error("bad pointer transaction carries a chunk size");

endmodule
